// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

   // Configuration register indexes.
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_LIMIT   = 1'b1;

   localparam int CSR_WIDTH = 10;

   // Frame command bytes.
   localparam logic [7:0] CMD_DATA    = 8'h40;
   localparam logic [7:0] CMD_ADDRESS = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY = 8'h88;
   localparam logic [2:0] BRIGHT_DEFAULT = 3'd3;

   localparam logic [9:0] PHASE_TICKS_RESET = 10'd3;
   localparam logic [7:0] ACK_LIMIT_RESET   = 8'd250;

   localparam int NUM_SEGS = 22;

   // Segment patterns: 0-9, A b c d E F H L n P U, blank.
   localparam logic [7:0] SEG_TABLE [NUM_SEGS] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h77,
      8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h76, 8'h38, 8'h54, 8'h73, 8'h3E, 8'h00
   };

   // One request as it travels from the input register to the sequencer.
   typedef struct packed {
      logic       req_type;
      logic [4:0] digit_zero;
      logic [4:0] digit_one;
      logic [4:0] digit_two;
      logic [4:0] digit_three;
      logic       colon_on;
      logic [7:0] brightness;
      logic       dio_sample;
   } req_type_t_type;

   // Codes above the table show blank.
   function automatic logic [7:0] seg_of(input logic [4:0] code);
      logic [7:0] seg;
      seg = 8'h00;
      if (code < 5'(NUM_SEGS)) begin
         seg = SEG_TABLE[code];
      end
      return seg;
   endfunction

endpackage

// ===== rtl/ssd_req_stage.sv =====
`timescale 1ns / 1ps

module ssd_req_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  ssd_pkg::req_type_t_type       up_req,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output ssd_pkg::req_type_t_type       dn_req
);

   logic                    valid_ff;
   ssd_pkg::req_type_t_type req_ff;

   // The register takes a new request whenever it is empty or being drained.
   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         req_ff <= up_req;
      end
   end

endmodule

// ===== rtl/ssd_sequencer.sv =====
`timescale 1ns / 1ps

module ssd_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [ssd_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ssd_pkg::req_type_t_type       in_req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_clk_level,
   output logic                          rsp_dio_level,
   output logic                          rsp_dio_drive,
   output logic                          rsp_busy_res,
   output logic                          rsp_update_done
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
      PH_ACK_WAIT, PH_ACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_STOP_D
   } phase_type;

   localparam logic [2:0] LAST_BYTE = 3'd6;

   // Configuration.
   logic [9:0] phase_ticks_ff;
   logic [7:0] ack_limit_ff;

   // Sequencer state.
   logic [7:0] frame_bytes_ff [5];
   phase_type  phase_ff, phase_in;
   logic [2:0] byte_idx_ff, byte_idx_in;
   logic [3:0] bit_idx_ff, bit_idx_in;
   logic [9:0] phase_cnt_ff, phase_cnt_in;
   logic [7:0] ack_cnt_ff, ack_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic       active_ff, active_in;

   // Result register.
   logic rsp_valid_ff;
   logic clk_ff, dio_ff, drive_ff, busy_ff, done_ff;
   logic clk_in, dio_in, drive_in, done_in;

   logic       take;
   logic       latch;
   logic       tick;
   logic       adv;
   logic [9:0] phase_cnt_inc;
   logic [2:0] byte_next;
   logic [7:0] byte_load;
   logic [2:0] bright;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign latch    = take && in_req.req_type && !active_ff;
   assign tick     = take && !in_req.req_type;
   assign phase_cnt_inc = phase_cnt_ff + 10'd1;
   assign bright   = (in_req.brightness > 8'd7) ? ssd_pkg::BRIGHT_DEFAULT
                                                 : in_req.brightness[2:0];

   // Byte that follows the current one in the sequence.
   assign byte_next = byte_idx_ff + 3'd1;
   always_comb begin
      case (byte_next)
         3'd0:    byte_load = ssd_pkg::CMD_DATA;
         3'd1:    byte_load = ssd_pkg::CMD_ADDRESS;
         3'd2:    byte_load = frame_bytes_ff[0];
         3'd3:    byte_load = frame_bytes_ff[1];
         3'd4:    byte_load = frame_bytes_ff[2];
         3'd5:    byte_load = frame_bytes_ff[3];
         default: byte_load = frame_bytes_ff[4];
      endcase
   end

   // Decide whether the current phase ends on this tick.
   always_comb begin
      adv        = 1'b0;
      ack_cnt_in = ack_cnt_ff;
      phase_cnt_in = phase_cnt_ff;
      if (tick && active_ff) begin
         if (phase_ff == PH_ACK_WAIT) begin
            if (!in_req.dio_sample || ack_cnt_ff >= ack_limit_ff) begin
               adv = 1'b1;
            end else begin
               ack_cnt_in = ack_cnt_ff + 8'd1;
            end
         end else begin
            phase_cnt_in = phase_cnt_inc;
            adv = phase_cnt_inc >= phase_ticks_ff;
         end
      end
      if (latch) begin
         ack_cnt_in   = 8'd0;
         phase_cnt_in = 10'd0;
      end else if (adv) begin
         phase_cnt_in = 10'd0;
         if (phase_ff == PH_ACK_LOW) begin
            ack_cnt_in = 8'd0;
         end
      end
   end

   // Phase transitions.
   always_comb begin
      phase_in    = phase_ff;
      byte_idx_in = byte_idx_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      active_in   = active_ff;
      done_in     = 1'b0;
      if (latch) begin
         phase_in    = PH_START_A;
         byte_idx_in = 3'd0;
         bit_idx_in  = 4'd0;
         shift_in    = ssd_pkg::CMD_DATA;
         active_in   = 1'b1;
      end else if (adv) begin
         case (phase_ff)
            PH_START_A: phase_in = PH_START_B;
            PH_START_B: phase_in = PH_BIT_LOW;
            PH_BIT_LOW: phase_in = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
               shift_in   = {1'b0, shift_ff[7:1]};
               bit_idx_in = bit_idx_ff + 4'd1;
               phase_in   = (bit_idx_in >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW:  phase_in = PH_ACK_WAIT;
            PH_ACK_WAIT: phase_in = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
               if (byte_idx_ff == 3'd0 || byte_idx_ff >= 3'd5) begin
                  phase_in = PH_STOP_A;
               end else begin
                  byte_idx_in = byte_next;
                  shift_in    = byte_load;
                  bit_idx_in  = 4'd0;
                  phase_in    = PH_BIT_LOW;
               end
            end
            PH_STOP_A: phase_in = PH_STOP_B;
            PH_STOP_B: phase_in = PH_STOP_C;
            PH_STOP_C: phase_in = PH_STOP_D;
            PH_STOP_D: begin
               if (byte_idx_ff >= LAST_BYTE) begin
                  phase_in  = PH_IDLE;
                  active_in = 1'b0;
                  done_in   = 1'b1;
               end else begin
                  byte_idx_in = byte_next;
                  shift_in    = byte_load;
                  bit_idx_in  = 4'd0;
                  phase_in    = PH_START_A;
               end
            end
            default: begin
               phase_in  = PH_IDLE;
               active_in = 1'b0;
            end
         endcase
      end
   end

   // Wire levels that follow from the phase reached.
   always_comb begin
      clk_in   = 1'b1;
      dio_in   = 1'b1;
      drive_in = 1'b1;
      case (phase_in)
         PH_START_B:  dio_in = 1'b0;
         PH_BIT_LOW: begin
            clk_in = 1'b0;
            dio_in = shift_in[0];
         end
         PH_BIT_HIGH: dio_in = shift_in[0];
         PH_ACK_LOW, PH_ACK_WAIT, PH_STOP_A: begin
            clk_in   = 1'b0;
            dio_in   = 1'b0;
            drive_in = 1'b0;
         end
         PH_ACK_HIGH: begin
            dio_in   = 1'b0;
            drive_in = 1'b0;
         end
         PH_STOP_B: begin
            clk_in = 1'b0;
            dio_in = 1'b0;
         end
         PH_STOP_C: dio_in = 1'b0;
         default: ;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= ssd_pkg::PHASE_TICKS_RESET;
         ack_limit_ff   <= ssd_pkg::ACK_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ssd_pkg::CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata;
            ssd_pkg::CSR_ACK_LIMIT:   ack_limit_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Frame bytes latched on an update taken while the sequencer is idle.
   always_ff @(posedge clock) begin
      if (latch) begin
         frame_bytes_ff[0] <= ssd_pkg::seg_of(in_req.digit_zero);
         frame_bytes_ff[1] <= ssd_pkg::seg_of(in_req.digit_one) | {in_req.colon_on, 7'd0};
         frame_bytes_ff[2] <= ssd_pkg::seg_of(in_req.digit_two);
         frame_bytes_ff[3] <= ssd_pkg::seg_of(in_req.digit_three);
         frame_bytes_ff[4] <= ssd_pkg::CMD_DISPLAY | {5'd0, bright};
      end
   end

   // Sequencer state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         byte_idx_ff  <= 3'd0;
         bit_idx_ff   <= 4'd0;
         phase_cnt_ff <= 10'd0;
         ack_cnt_ff   <= 8'd0;
         shift_ff     <= 8'd0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         byte_idx_ff  <= byte_idx_in;
         bit_idx_ff   <= bit_idx_in;
         phase_cnt_ff <= phase_cnt_in;
         ack_cnt_ff   <= ack_cnt_in;
         shift_ff     <= shift_in;
         active_ff    <= active_in;
         if (in_ready) begin
            rsp_valid_ff <= tick;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         clk_ff   <= clk_in;
         dio_ff   <= drive_in & dio_in;
         drive_ff <= drive_in;
         busy_ff  <= active_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clk_level   = clk_ff;
   assign rsp_dio_level   = dio_ff;
   assign rsp_dio_drive   = drive_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_update_done = done_ff;

   // A finished update leaves the bus idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && clk_ff && dio_ff && drive_ff)
      else $error("update_done without idle bus");

   // While idle the lines stay high and driven.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !busy_ff |-> clk_ff && dio_ff && drive_ff)
      else $error("idle result with bus not high");

   // The sequencer is active exactly when it is out of the idle phase.
   assert property (@(posedge clock) disable iff (reset)
      active_ff == (phase_ff != PH_IDLE))
      else $error("active flag and phase disagree");

   // An update request never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      take && in_req.req_type |=> !rsp_valid_ff)
      else $error("result after update request");

endmodule

// ===== rtl/seven_segment_two_wire_display_driver.sv =====
`timescale 1ns / 1ps

// Channel   Ports                              Moves
// req       req_valid / req_ready, fields      one request: a tick or an update
// rsp       rsp_valid / rsp_ready, fields      wire levels after one tick
// csr       csr_write, csr_index, csr_wdata    phase length, acknowledge limit
//
// One request per cycle is taken while the result is not stalled; a tick's result passes
// through the input register, then a sequencer step into the result register.
// Update requests update the frame state only while the sequencer is idle; none gives a result.
// Reset is synchronous and returns the sequencer to idle; the next tick shows both lines high.
// A stalled result holds back the sequencer; the input register still fills.

module seven_segment_two_wire_display_driver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [ssd_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [4:0]                    req_digit_zero,
   input  logic [4:0]                    req_digit_one,
   input  logic [4:0]                    req_digit_two,
   input  logic [4:0]                    req_digit_three,
   input  logic                          req_colon_on,
   input  logic [7:0]                    req_brightness,
   input  logic                          req_dio_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_clk_level,
   output logic                          rsp_dio_level,
   output logic                          rsp_dio_drive,
   output logic                          rsp_busy_res,
   output logic                          rsp_update_done
);

   ssd_pkg::req_type_t_type up_req;
   ssd_pkg::req_type_t_type stage_req;
   logic                    stage_valid;
   logic                    stage_ready;

   // Gather the request fields.
   always_comb begin
      up_req.req_type    = req_type;
      up_req.digit_zero  = req_digit_zero;
      up_req.digit_one   = req_digit_one;
      up_req.digit_two   = req_digit_two;
      up_req.digit_three = req_digit_three;
      up_req.colon_on    = req_colon_on;
      up_req.brightness  = req_brightness;
      up_req.dio_sample  = req_dio_sample;
   end

   ssd_req_stage u_req_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_req   (up_req),
      .dn_valid (stage_valid),
      .dn_ready (stage_ready),
      .dn_req   (stage_req)
   );

   ssd_sequencer u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_valid        (stage_valid),
      .in_ready        (stage_ready),
      .in_req          (stage_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_clk_level   (rsp_clk_level),
      .rsp_dio_level   (rsp_dio_level),
      .rsp_dio_drive   (rsp_dio_drive),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_update_done (rsp_update_done)
   );

endmodule
